// ===== hw/rtl/minirv_pkg.sv =====
// shared types, opcodes and sizes for the minirv instruction executor
// no dependencies; imported by every module of the block but minirv_ram

package minirv_pkg;

  localparam int XLEN          = 32;
  localparam int REG_IDX_W     = 4;
  localparam int NUM_REGS      = 1 << REG_IDX_W;
  localparam int MEM_ADDR_BITS = 10;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;

  localparam logic [2:0] F3_ADD   = 3'b000;
  localparam logic [2:0] F3_BYTE  = 3'b000;
  localparam logic [2:0] F3_WORD  = 3'b010;
  localparam logic [2:0] F3_BYTEU = 3'b100;
  localparam logic [2:0] F3_JALR  = 3'b000;
  localparam logic [6:0] F7_ADD   = 7'b0000000;

  localparam logic [XLEN-1:0] JALR_MASK = 32'hfffffffe;
  localparam int              IMM_W     = 12;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_REG,
    OP_LW,
    OP_LBU,
    OP_SW,
    OP_SB,
    OP_PRELOAD
  } op_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      value;
  } reg_wr_t;

  typedef struct packed {
    logic                     valid;
    op_t                      op;
    logic [MEM_ADDR_BITS-1:0] word;
    logic [1:0]               lane;
    logic [XLEN-1:0]          data;
  } mem_req_t;

  typedef struct packed {
    logic                     we;
    logic [MEM_ADDR_BITS-1:0] word;
    logic [3:0]               mask;
    logic [XLEN-1:0]          value;
    logic [XLEN-1:0]          load_value;
  } mem_res_t;

endpackage

// ===== hw/rtl/minirv_instruction_executor_core.sv =====
// minirv instruction executor: decode/execute pipeline around register and data rams
// depends on minirv_pkg, minirv_regfile, minirv_lsu
//
// s channel: one item per instruction (s_tuser 0) or per memory preload (s_tuser 1)
// m channel: one result item per input item, in order
// pipeline: register read, execute and address, memory access and write-back,
//   then an output register
// throughput: one item per cycle; every stage moves together whenever the output
//   register is empty or being taken, so s_tready is low only while a result waits
// results of an older item reach a younger one through forwarding paths around the
//   register file and data memory reads, so no dependency stalls the pipeline
// reset: pc and all registers read as zero at once (valid bits), the data memory
//   is undefined until written and takes no clearing pass; the pipeline empties
// receiver stall: the result holds on m_tdata and the whole pipeline holds with it

module minirv_instruction_executor_core
  import minirv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // instr[31:0], preload_word_addr[41:32], preload_data[73:42], zero[79:74]
  input  logic [79:0]  s_tdata,
  // req_type
  input  logic [0:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // next_pc[31:0], reg_we[32], reg_index[36:33], reg_value[68:37], mem_we[69],
  // mem_word[79:70], mem_byte_mask[83:80], mem_value[115:84], recognized[116], zero[119:117]
  output logic [119:0] m_tdata
);

  logic adv;

  logic [XLEN-1:0] pc;

  logic                     s1_valid;
  logic                     s1_preload;
  logic [XLEN-1:0]          s1_instr;
  logic [MEM_ADDR_BITS-1:0] s1_pword;
  logic [XLEN-1:0]          s1_pdata;

  logic [XLEN-1:0]      rs1_data;
  logic [XLEN-1:0]      rs2_data;
  logic [6:0]           opc;
  logic [2:0]           f3;
  logic [6:0]           f7;
  logic [REG_IDX_W-1:0] rd;
  logic [XLEN-1:0]      imm_i;
  logic [XLEN-1:0]      imm_s;
  logic [XLEN-1:0]      sum;
  logic [XLEN-1:0]      pc_plus4;
  op_t                  s1_op;
  logic                 s1_wr;
  logic [XLEN-1:0]      s1_wv;
  logic [XLEN-1:0]      s1_next_pc;
  logic                 s1_recog;
  mem_req_t             s1_mreq;

  logic                 s2_valid;
  logic                 s2_rwe;
  logic [REG_IDX_W-1:0] s2_rd;
  logic [XLEN-1:0]      s2_wv;
  logic [XLEN-1:0]      s2_next_pc;
  logic                 s2_recog;
  mem_req_t             s2_mreq;
  mem_res_t             mres;
  reg_wr_t              s2_wr;

  logic                     m_valid;
  logic [XLEN-1:0]          out_next_pc;
  reg_wr_t                  out_reg;
  logic                     out_mem_we;
  logic [MEM_ADDR_BITS-1:0] out_mem_word;
  logic [3:0]               out_mask;
  logic [XLEN-1:0]          out_mem_value;
  logic                     out_recog;

  assign adv      = !m_valid || m_tready;
  assign s_tready = adv;
  assign m_tvalid = m_valid;

  minirv_regfile u_regfile (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .rs1_addr (s_tdata[18:15]),
    .rs2_addr (s_tdata[23:20]),
    .wr       (s2_wr),
    .rs1_data (rs1_data),
    .rs2_data (rs2_data)
  );

  // execute stage
  assign opc      = s1_instr[6:0];
  assign f3       = s1_instr[14:12];
  assign f7       = s1_instr[31:25];
  assign rd       = s1_instr[10:7];
  assign imm_i    = {{(XLEN-IMM_W){s1_instr[31]}}, s1_instr[31:20]};
  assign imm_s    = {{(XLEN-IMM_W){s1_instr[31]}}, s1_instr[31:25], s1_instr[11:7]};
  assign sum      = rs1_data + ((opc == OPC_STORE) ? imm_s : imm_i);
  assign pc_plus4 = pc + 32'd4;

  always_comb begin
    s1_op      = OP_NONE;
    s1_wr      = 1'b0;
    s1_wv      = '0;
    s1_next_pc = pc_plus4;
    s1_recog   = 1'b0;
    if (s1_preload) begin
      s1_op      = OP_PRELOAD;
      s1_next_pc = pc;
    end else begin
      case (opc)
        OPC_OP_IMM: begin
          if (f3 == F3_ADD) begin
            s1_op = OP_REG;
            s1_wr = 1'b1;
            s1_wv = sum;
          end
        end
        OPC_OP: begin
          if (f3 == F3_ADD && f7 == F7_ADD) begin
            s1_op = OP_REG;
            s1_wr = 1'b1;
            s1_wv = rs1_data + rs2_data;
          end
        end
        OPC_LUI: begin
          s1_op = OP_REG;
          s1_wr = 1'b1;
          s1_wv = {s1_instr[31:12], 12'b0};
        end
        OPC_LOAD: begin
          if (f3 == F3_WORD) begin
            s1_op = OP_LW;
            s1_wr = 1'b1;
          end else if (f3 == F3_BYTEU) begin
            s1_op = OP_LBU;
            s1_wr = 1'b1;
          end
        end
        OPC_STORE: begin
          if (f3 == F3_WORD) begin
            s1_op = OP_SW;
          end else if (f3 == F3_BYTE) begin
            s1_op = OP_SB;
          end
        end
        OPC_JALR: begin
          if (f3 == F3_JALR) begin
            s1_op      = OP_REG;
            s1_wr      = 1'b1;
            s1_wv      = pc_plus4;
            s1_next_pc = sum & JALR_MASK;
          end
        end
        default: begin
          s1_op = OP_NONE;
        end
      endcase
      s1_recog = (s1_op != OP_NONE);
    end
  end

  always_comb begin
    s1_mreq       = '0;
    s1_mreq.valid = s1_valid;
    s1_mreq.op    = s1_op;
    s1_mreq.lane  = sum[1:0];
    if (s1_preload) begin
      s1_mreq.word = s1_pword;
      s1_mreq.data = s1_pdata;
    end else begin
      s1_mreq.word = sum[MEM_ADDR_BITS+1:2];
      s1_mreq.data = rs2_data;
    end
  end

  minirv_lsu u_lsu (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .rd_word (s1_mreq.word),
    .req     (s2_mreq),
    .res     (mres)
  );

  // write-back stage
  always_comb begin
    s2_wr.we    = s2_valid && s2_rwe;
    s2_wr.idx   = s2_rwe ? s2_rd : '0;
    s2_wr.value = '0;
    if (s2_rwe) begin
      if (s2_mreq.op == OP_LW || s2_mreq.op == OP_LBU) begin
        s2_wr.value = mres.load_value;
      end else begin
        s2_wr.value = s2_wv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc       <= '0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_valid  <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
      m_valid  <= s2_valid;
      if (s1_valid) begin
        pc <= s1_next_pc;
      end
    end
    if (adv) begin
      s1_preload <= s_tuser[0];
      s1_instr   <= s_tdata[31:0];
      s1_pword   <= s_tdata[41:32];
      s1_pdata   <= s_tdata[73:42];

      s2_rwe     <= s1_wr && (rd != '0);
      s2_rd      <= rd;
      s2_wv      <= s1_wv;
      s2_next_pc <= s1_next_pc;
      s2_recog   <= s1_recog;
      s2_mreq    <= s1_mreq;

      out_next_pc   <= s2_next_pc;
      out_reg       <= s2_wr;
      out_mem_we    <= mres.we;
      out_mem_word  <= mres.word;
      out_mask      <= mres.mask;
      out_mem_value <= mres.value;
      out_recog     <= s2_recog;
    end
  end

  assign m_tdata = {3'b000, out_recog, out_mem_value, out_mask, out_mem_word, out_mem_we,
                    out_reg.value, out_reg.idx, out_reg.we, out_next_pc};

`ifndef SYNTHESIS
  a_stall_holds_pc: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_tready) |=> $stable(pc))
    else $error("pc moved while the pipeline was stalled");

  a_preload_keeps_pc: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && s1_preload) |=> $stable(pc))
    else $error("preload item changed the pc");

  a_no_x0_write: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_rwe) |-> (s2_rd != '0))
    else $error("write-back targets x0");

  a_mem_write_has_lanes: assert property (@(posedge clk) disable iff (rst)
    (m_valid && out_mem_we) |-> (out_mask != 4'b0000))
    else $error("memory write reported with no byte lanes");
`endif

endmodule

// ===== hw/rtl/minirv_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// read-first on a same-address collision; no dependencies

module minirv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/minirv_regfile.sv =====
// register file: two ram copies for the two source reads, valid bits for reset
// depends on minirv_pkg and minirv_ram; forwards the write in flight and the last one

module minirv_regfile
  import minirv_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic [REG_IDX_W-1:0] rs1_addr,
  input  logic [REG_IDX_W-1:0] rs2_addr,
  input  reg_wr_t              wr,
  output logic [XLEN-1:0]      rs1_data,
  output logic [XLEN-1:0]      rs2_data
);

  logic                 commit;
  logic [NUM_REGS-1:0]  vld;
  logic [REG_IDX_W-1:0] rs1_q;
  logic [REG_IDX_W-1:0] rs2_q;
  reg_wr_t              prev;
  logic [XLEN-1:0]      ram1_q;
  logic [XLEN-1:0]      ram2_q;

  assign commit = adv && wr.we;

  minirv_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_copy1 (
    .clk   (clk),
    .we    (commit),
    .waddr (wr.idx),
    .wdata (wr.value),
    .re    (adv),
    .raddr (rs1_addr),
    .rdata (ram1_q)
  );

  minirv_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_copy2 (
    .clk   (clk),
    .we    (commit),
    .waddr (wr.idx),
    .wdata (wr.value),
    .re    (adv),
    .raddr (rs2_addr),
    .rdata (ram2_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      prev.we <= 1'b0;
    end else if (adv) begin
      prev.we <= wr.we;
      if (wr.we) begin
        vld[wr.idx] <= 1'b1;
      end
    end
    if (adv) begin
      rs1_q      <= rs1_addr;
      rs2_q      <= rs2_addr;
      prev.idx   <= wr.idx;
      prev.value <= wr.value;
    end
  end

  // newest write wins, then the one the ram missed, then the array, else zero if never written
  always_comb begin
    if (wr.we && wr.idx == rs1_q) begin
      rs1_data = wr.value;
    end else if (prev.we && prev.idx == rs1_q) begin
      rs1_data = prev.value;
    end else if (vld[rs1_q]) begin
      rs1_data = ram1_q;
    end else begin
      rs1_data = '0;
    end

    if (wr.we && wr.idx == rs2_q) begin
      rs2_data = wr.value;
    end else if (prev.we && prev.idx == rs2_q) begin
      rs2_data = prev.value;
    end else if (vld[rs2_q]) begin
      rs2_data = ram2_q;
    end else begin
      rs2_data = '0;
    end
  end

`ifndef SYNTHESIS
  a_x0_never_valid: assert property (@(posedge clk) disable iff (rst)
    !vld[0])
    else $error("register x0 marked as written");
`endif

endmodule

// ===== hw/rtl/minirv_lsu.sv =====
// data memory and load/store unit: word ram, store merge, load lane select
// depends on minirv_pkg and minirv_ram; forwards the previous write to the next read

module minirv_lsu
  import minirv_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic [MEM_ADDR_BITS-1:0] rd_word,
  input  mem_req_t                 req,
  output mem_res_t                 res
);

  logic                     commit;
  logic [XLEN-1:0]          ram_q;
  logic [XLEN-1:0]          word_data;
  logic                     prev_we;
  logic [MEM_ADDR_BITS-1:0] prev_word;
  logic [XLEN-1:0]          prev_value;
  logic [XLEN-1:0]          merged;

  assign commit = adv && req.valid && res.we;

  minirv_ram #(.WIDTH(XLEN), .DEPTH(MEM_DEPTH)) u_dmem (
    .clk   (clk),
    .we    (commit),
    .waddr (res.word),
    .wdata (res.value),
    .re    (adv),
    .raddr (rd_word),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_we <= 1'b0;
    end else if (adv) begin
      prev_we <= commit;
    end
    if (adv) begin
      prev_word  <= res.word;
      prev_value <= res.value;
    end
  end

  assign word_data = (prev_we && prev_word == req.word) ? prev_value : ram_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      merged[i*8 +: 8] = (req.lane == i[1:0]) ? req.data[7:0] : word_data[i*8 +: 8];
    end
  end

  always_comb begin
    res            = '0;
    res.load_value = '0;
    case (req.op)
      OP_PRELOAD, OP_SW: begin
        res.we    = 1'b1;
        res.word  = req.word;
        res.mask  = 4'b1111;
        res.value = req.data;
      end
      OP_SB: begin
        res.we    = 1'b1;
        res.word  = req.word;
        res.mask  = 4'b0001 << req.lane;
        res.value = merged;
      end
      OP_LW: begin
        res.load_value = word_data;
      end
      OP_LBU: begin
        res.load_value = {24'b0, word_data[{req.lane, 3'b000} +: 8]};
      end
      default: begin
        res.we = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_sb_one_lane: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.op == OP_SB) |-> $onehot(res.mask))
    else $error("byte store must write exactly one lane");
`endif

endmodule

// ===== sim/minirv_exec_checker.sv =====
// checker for the minirv instruction executor: predicts each result item from accepted
// input items and compares it field by field; depends on minirv_pkg only
`timescale 1ns / 1ps

module minirv_exec_checker
  import minirv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [79:0]  s_tdata,
  input  logic [0:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [119:0] m_tdata,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic [5:0]               pad;
    logic [XLEN-1:0]          pre_data;
    logic [MEM_ADDR_BITS-1:0] pre_word;
    logic [XLEN-1:0]          instr;
  } exec_req_t;

  typedef struct packed {
    logic [2:0]               pad;
    logic                     recognized;
    logic [XLEN-1:0]          mem_value;
    logic [3:0]               mem_mask;
    logic [MEM_ADDR_BITS-1:0] mem_word;
    logic                     mem_we;
    logic [XLEN-1:0]          reg_value;
    logic [REG_IDX_W-1:0]     reg_index;
    logic                     reg_we;
    logic [XLEN-1:0]          next_pc;
  } exec_result_t;

  logic [XLEN-1:0] pc_q;
  logic [XLEN-1:0] regs [NUM_REGS];
  logic [XLEN-1:0] dmem [MEM_DEPTH];
  exec_result_t    expected_q[$];
  exec_result_t    want, got;
  logic            bad;

  function automatic exec_result_t execute(input logic preload, input exec_req_t rq);
    exec_result_t             r;
    logic [6:0]               opc, f7;
    logic [2:0]               f3;
    logic [REG_IDX_W-1:0]     rd, rs1, rs2;
    logic [XLEN-1:0]          a, b, imm_i, imm_s, addr, wv;
    logic [MEM_ADDR_BITS-1:0] w;
    logic [4:0]               sh;
    logic                     wr;
    r = '0;
    r.next_pc = pc_q;
    if (preload) begin
      dmem[rq.pre_word] = rq.pre_data;
      r.mem_we    = 1'b1;
      r.mem_word  = rq.pre_word;
      r.mem_mask  = 4'hf;
      r.mem_value = rq.pre_data;
      return r;
    end
    opc   = rq.instr[6:0];
    f3    = rq.instr[14:12];
    f7    = rq.instr[31:25];
    rd    = rq.instr[10:7];
    rs1   = rq.instr[18:15];
    rs2   = rq.instr[23:20];
    a     = regs[rs1];
    b     = regs[rs2];
    imm_i = {{20{rq.instr[31]}}, rq.instr[31:20]};
    imm_s = {{20{rq.instr[31]}}, rq.instr[31:25], rq.instr[11:7]};
    wr    = 1'b0;
    wv    = '0;
    r.next_pc = pc_q + 32'd4;
    if (opc == OPC_OP_IMM && f3 == F3_ADD) begin
      r.recognized = 1'b1;
      wr = 1'b1;
      wv = a + imm_i;
    end else if (opc == OPC_OP && f3 == F3_ADD && f7 == F7_ADD) begin
      r.recognized = 1'b1;
      wr = 1'b1;
      wv = a + b;
    end else if (opc == OPC_LUI) begin
      r.recognized = 1'b1;
      wr = 1'b1;
      wv = {rq.instr[31:12], 12'b0};
    end else if (opc == OPC_LOAD && (f3 == F3_WORD || f3 == F3_BYTEU)) begin
      addr = a + imm_i;
      w    = addr[MEM_ADDR_BITS+1:2];
      sh   = {addr[1:0], 3'b000};
      r.recognized = 1'b1;
      wr = 1'b1;
      wv = (f3 == F3_WORD) ? dmem[w] : ((dmem[w] >> sh) & 32'hff);
    end else if (opc == OPC_STORE && (f3 == F3_BYTE || f3 == F3_WORD)) begin
      addr = a + imm_s;
      w    = addr[MEM_ADDR_BITS+1:2];
      sh   = {addr[1:0], 3'b000};
      r.recognized = 1'b1;
      if (f3 == F3_WORD) begin
        r.mem_value = b;
        r.mem_mask  = 4'hf;
      end else begin
        r.mem_value = (dmem[w] & ~(32'hff << sh)) | ({24'b0, b[7:0]} << sh);
        r.mem_mask  = 4'b0001 << addr[1:0];
      end
      dmem[w]    = r.mem_value;
      r.mem_we   = 1'b1;
      r.mem_word = w;
    end else if (opc == OPC_JALR && f3 == F3_JALR) begin
      r.recognized = 1'b1;
      wr = 1'b1;
      wv = pc_q + 32'd4;
      r.next_pc = (a + imm_i) & JALR_MASK;
    end
    if (wr && rd != '0) begin
      regs[rd]    = wv;
      r.reg_we    = 1'b1;
      r.reg_index = rd;
      r.reg_value = wv;
    end
    pc_q = r.next_pc;
    return r;
  endfunction

  function automatic string show(input exec_result_t r);
    return $sformatf("pc=%h rwe=%b x%0d=%h mwe=%b word=%0d mask=%b val=%h rec=%b pad=%b",
                     r.next_pc, r.reg_we, r.reg_index, r.reg_value, r.mem_we, r.mem_word,
                     r.mem_mask, r.mem_value, r.recognized, r.pad);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pc_q = '0;
      for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (s_tvalid && s_tready) expected_q.push_back(execute(s_tuser[0], s_tdata));
      if (m_tvalid === 1'b1 && m_tready) begin
        got = m_tdata;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("checker: result item with nothing expected: %s", show(got));
        end else begin
          want = expected_q.pop_front();
          bad = (got.next_pc !== want.next_pc) || (got.reg_we !== want.reg_we) ||
                (got.reg_index !== want.reg_index) || (got.reg_value !== want.reg_value) ||
                (got.mem_we !== want.mem_we) || (got.mem_word !== want.mem_word) ||
                (got.mem_mask !== want.mem_mask) || (got.mem_value !== want.mem_value) ||
                (got.recognized !== want.recognized) || (got.pad !== want.pad);
          if (bad) begin
            errors++;
            if (errors <= 10) begin
              $display("checker: mismatch, expected %s", show(want));
              $display("checker:             actual %s", show(got));
            end
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// testbench top for minirv_instruction_executor_core: directed and random instruction
// streams with random idling on both channels; depends on minirv_pkg, core and checker
`timescale 1ns / 1ps

module tb_top;
  import minirv_pkg::*;

  localparam logic [6:0] F7_SUB = 7'b0100000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [79:0]  s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  int           fail_count;
  int           outstanding;

  bit           written_map [MEM_DEPTH];
  int           written_list[$];
  bit           no_idle;
  int           n_items, n_preload, n_load, n_store, n_jump, n_other, n_pauses;

  minirv_instruction_executor_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  minirv_exec_checker u_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .errors(fail_count), .pending(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [4:0] reg5(input logic [3:0] r);
    return {1'($urandom_range(0, 1)), r};
  endfunction

  function automatic logic [31:0] enc_i(input logic [6:0] opc, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_r(input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [6:0] f7);
    return {f7, rs2, rs1, F3_ADD, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_u(input logic [4:0] rd, input logic [19:0] imm);
    return {imm, rd, OPC_LUI};
  endfunction

  // loads and byte stores must never touch a word that was never written
  function automatic logic [31:0] sanitize(input logic [31:0] ins);
    if ((ins[6:0] == OPC_LOAD && (ins[14:12] == F3_WORD || ins[14:12] == F3_BYTEU)) ||
        (ins[6:0] == OPC_STORE && ins[14:12] == F3_BYTE))
      ins[2] = ~ins[2];
    return ins;
  endfunction

  function automatic logic [31:0] rand_alu();
    logic [11:0] imm;
    imm = 12'($urandom);
    case ($urandom_range(0, 3))
      0: return enc_i(OPC_OP_IMM, F3_ADD, reg5(4'($urandom)), reg5(4'($urandom)), imm);
      1: return enc_r(reg5(4'($urandom)), reg5(4'($urandom)), reg5(4'($urandom)), F7_ADD);
      2: return enc_u(reg5(4'($urandom)), 20'($urandom));
      default: return enc_i(OPC_JALR, F3_JALR, reg5(4'($urandom)), reg5(4'($urandom)), imm);
    endcase
  endfunction

  function automatic void mark(input logic [MEM_ADDR_BITS-1:0] w);
    if (!written_map[w]) begin
      written_map[w] = 1'b1;
      written_list.push_back(int'(w));
    end
  endfunction

  task automatic send(input bit preload, input logic [31:0] ins,
                      input logic [MEM_ADDR_BITS-1:0] w, input logic [31:0] d);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= preload;
    s_tdata  <= {6'b0, d, w, ins};
    do @(posedge clk); while (!s_tready);
    n_items++;
    if (preload) n_preload++;
    else case (ins[6:0])
      OPC_LOAD:  n_load++;
      OPC_STORE: n_store++;
      OPC_JALR:  n_jump++;
      default:   n_other++;
    endcase
  endtask

  task automatic exec(input logic [31:0] ins);
    send(1'b0, ins, MEM_ADDR_BITS'($urandom), $urandom);
  endtask

  task automatic preload_word(input logic [MEM_ADDR_BITS-1:0] w, input logic [31:0] d);
    send(1'b1, $urandom, w, d);
    mark(w);
  endtask

  task automatic quiesce();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    n_pauses++;
  endtask

  // base x0 or built by lui/addi, a load or store through it, a store maybe read back
  task automatic mem_access();
    logic [31:0]              target, base, hi, lo;
    logic [11:0]              imm;
    logic [3:0]               rb, rv;
    logic [MEM_ADDR_BITS-1:0] w;
    int                       kind;
    kind = $urandom_range(0, 3);
    if (kind != 2 && written_list.size() == 0) kind = 2;
    if (kind == 2) w = MEM_ADDR_BITS'($urandom);
    else w = MEM_ADDR_BITS'(written_list[$urandom_range(0, written_list.size() - 1)]);
    rv = 4'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      rb  = '0;
      imm = {w, 2'($urandom)};
    end else begin
      rb     = 4'($urandom_range(1, 15));
      imm    = 12'($urandom);
      target = {20'($urandom), w, 2'($urandom)};
      base   = target - {{20{imm[11]}}, imm};
      hi     = (base + 32'h800) & 32'hfffff000;
      lo     = base - hi;
      exec(enc_u(reg5(rb), hi[31:12]));
      exec(enc_i(OPC_OP_IMM, F3_ADD, reg5(rb), reg5(rb), lo[11:0]));
    end
    case (kind)
      0: exec(enc_i(OPC_LOAD, F3_WORD, reg5(rv), reg5(rb), imm));
      1: exec(enc_i(OPC_LOAD, F3_BYTEU, reg5(rv), reg5(rb), imm));
      2: begin
        exec(enc_s(F3_WORD, reg5(rb), reg5(rv), imm));
        mark(w);
      end
      default: exec(enc_s(F3_BYTE, reg5(rb), reg5(rv), imm));
    endcase
    if (kind >= 2 && $urandom_range(0, 1))
      exec(enc_i(OPC_LOAD, $urandom_range(0, 1) ? F3_WORD : F3_BYTEU, reg5(4'($urandom)),
                 reg5(rb), imm));
  endtask

  initial begin
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  initial begin
    int pick, b, next_pause;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    no_idle  = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    preload_word(10'd0, 32'hffffffff);
    preload_word(10'd1023, 32'h80000001);
    preload_word(10'd512, 32'h00000000);
    exec(enc_u(5'd1, 20'hfffff));
    exec(enc_i(OPC_OP_IMM, F3_ADD, 5'd2, 5'd0, 12'h800));
    exec(enc_i(OPC_OP_IMM, F3_ADD, 5'd19, 5'd16, 12'h7ff));
    exec(enc_r(5'd4, 5'd1, 5'd2, F7_ADD));
    exec(enc_i(OPC_OP_IMM, F3_ADD, 5'd0, 5'd3, 12'h005));
    exec(enc_i(OPC_LOAD, F3_WORD, 5'd5, 5'd0, 12'h003));
    exec(enc_i(OPC_LOAD, F3_BYTEU, 5'd6, 5'd16, 12'hfff));
    exec(enc_s(F3_WORD, 5'd0, 5'd1, 12'hffc));
    exec(enc_s(F3_BYTE, 5'd0, 5'd3, 12'h001));
    exec(enc_s(F3_BYTE, 5'd0, 5'd2, 12'h800));
    exec(enc_i(OPC_LOAD, F3_WORD, 5'd7, 5'd0, 12'h000));
    exec(enc_i(OPC_LOAD, F3_BYTEU, 5'd8, 5'd0, 12'hffe));
    exec(enc_i(OPC_JALR, F3_JALR, 5'd1, 5'd1, 12'h7ff));
    exec(enc_i(OPC_JALR, F3_JALR, 5'd0, 5'd0, 12'hffe));
    exec(32'h00000000);
    exec(32'hffffffff);
    exec(enc_r(5'd9, 5'd1, 5'd2, F7_SUB));
    exec(enc_i(OPC_OP_IMM, F3_WORD, 5'd10, 5'd3, 12'h001));
    exec(enc_u(5'd31, 20'h80000));
    exec(enc_r(5'd15, 5'd31, 5'd15, F7_ADD));
    quiesce();

    next_pause = n_items + 230;
    while (n_items < 1150) begin
      if (n_items >= next_pause) begin
        quiesce();
        no_idle    = ($urandom_range(0, 2) == 0);
        next_pause = n_items + 230;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) mem_access();
      else if (pick < 55) preload_word(MEM_ADDR_BITS'($urandom), $urandom);
      else if (pick < 85) exec(rand_alu());
      else if (pick < 93) exec(sanitize($urandom));
      else begin
        b = $urandom_range(0, 16);
        b = (b < 7) ? b : ((b < 10) ? b + 5 : b + 15);
        exec(sanitize(rand_alu() ^ (32'h1 << b)));
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    $display("run covered %0d items: %0d preloads, %0d loads, %0d stores, %0d jumps,",
             n_items, n_preload, n_load, n_store, n_jump);
    $display("  %0d other instructions, %0d drain points, %0d written words tracked",
             n_other, n_pauses, written_list.size());
    if (fail_count == 0) begin
      $display("[minirv_instruction_executor_core] OK");
    end else begin
      $display("[minirv_instruction_executor_core] ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[minirv_instruction_executor_core] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/minirv_pkg.sv
hw/rtl/minirv_ram.sv
hw/rtl/minirv_regfile.sv
hw/rtl/minirv_lsu.sv
hw/rtl/minirv_instruction_executor_core.sv
sim/minirv_exec_checker.sv
sim/tb_top.sv
